### sv/cmnd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the context move-to-front nybble decoder.
// No dependencies; imported by cmnd_row_update and the top level.
package cmnd_pkg;

    localparam int LIST_LEN         = 8;
    localparam int CONTEXTS_DEFAULT = 16;
    localparam int APB_ADDR_W       = 3;
    localparam int APB_DATA_W       = 32;

    localparam logic [7:0] TYPE_NYBBLES = 8'hAF;
    localparam logic [7:0] TYPE_COPY    = 8'h20;

    // Word index of the adapt enable register
    localparam logic [APB_ADDR_W-3:0] REG_ADAPT_ENABLE = '0;

    typedef logic [LIST_LEN-1:0][7:0] mtf_row_t;

    // Entry 0 is the front of the list: space e t a o i n s
    localparam mtf_row_t INIT_ROW = {8'h73, 8'h6E, 8'h69, 8'h6F,
                                     8'h61, 8'h74, 8'h65, 8'h20};

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_SEED   = 2'd1,
        PH_BLOCK  = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       block_start;
    } code_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } dec_item_t;

endpackage

### sv/context_mtf_nybble_decoder_top.sv
`timescale 1ns / 1ps
// Top level of the context move-to-front nybble decoder.
// Depends on cmnd_pkg and cmnd_row_update.
//
//  channel  | signals                               | direction | moves
//  ---------+---------------------------------------+-----------+---------------------
//  code     | code_valid, code_ready, code_item     | in        | compressed byte + flag
//  dec      | dec_valid, dec_ready, dec_item        | out       | decoded byte + last
//  apb      | psel penable pwrite paddr pwdata ...  | in/out    | adapt_enable register
//
// Each request is held in an input register and decoded one output byte per step: a
// literal, copy or control byte at once, a nybble pair high half first, then low half,
// as the single row read port (row of the previous byte's context) serves one byte
// per cycle unless stalled. A new request is taken in the cycle the held one finishes.
// A stalled output register holds its byte; processing stops only when a byte is
// due and the output register cannot take it. Reset is asynchronous, active low;
// the context lists need no clearing pass: per-row valid flags read as the
// initial list until the row is written, and a block header drops all flags at once.
module context_mtf_nybble_decoder_top #(
    parameter int CONTEXTS = cmnd_pkg::CONTEXTS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cmnd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [cmnd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [cmnd_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,

    input  logic                            code_valid,
    output logic                            code_ready,
    input  cmnd_pkg::code_item_t            code_item,

    output logic                            dec_valid,
    input  logic                            dec_ready,
    output cmnd_pkg::dec_item_t             dec_item
);
    import cmnd_pkg::*;

    localparam int CTX_W = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;

    // Configuration
    logic adapt_reg;
    logic cfg_write;
    logic cfg_hit;

    // Held request
    logic       hold_valid_reg;
    logic       hold_half_reg;
    code_item_t hold_item_reg;
    logic [7:0] b;

    // Decoder state
    phase_t     phase_reg, phase_next;
    logic       pass_reg, pass_next;
    logic [7:0] prev_reg, prev_next;

    // Context lists
    mtf_row_t             row_mem [CONTEXTS];
    logic [CONTEXTS-1:0]  row_valid_reg;
    logic [CTX_W-1:0]     ctx_lut [32];
    logic [CTX_W-1:0]     ctx_rd;
    mtf_row_t             cur_row;
    mtf_row_t             upd_row;
    logic [2:0]           lookup_idx;
    logic [7:0]           looked;

    // Step control
    logic       has_out;
    logic       coded;
    logic       done;
    logic       clear_lists;
    logic [7:0] out_sym;
    logic       out_last;
    logic       out_space;
    logic       step;
    logic       row_write;

    // Output register
    logic      out_valid_reg;
    dec_item_t out_item_reg;

    // ------------------------------------------------------------------
    // Configuration port: one register, adapt_enable at word 0
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_hit   = (paddr[APB_ADDR_W-1:2] == REG_ADAPT_ENABLE);
    assign cfg_write = psel & penable & pwrite & pready;
    assign prdata    = cfg_hit ? {{(APB_DATA_W-1){1'b0}}, adapt_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adapt_reg <= 1'b1;
        end
        else if (cfg_write && cfg_hit)
        begin
            adapt_reg <= pwdata[0];
        end
    end

    // ------------------------------------------------------------------
    // Context of a byte: bits 7:3 folded onto the number of lists
    // ------------------------------------------------------------------
    for (genvar g = 0; g < 32; g++)
    begin : g_ctx
        assign ctx_lut[g] = CTX_W'(g % CONTEXTS);
    end

    // Every lookup and update uses the list of the previous output byte
    assign ctx_rd  = ctx_lut[prev_reg[7:3]];
    assign cur_row = row_valid_reg[ctx_rd] ? row_mem[ctx_rd] : INIT_ROW;

    assign b          = hold_item_reg.code_byte;
    // High nybble on the first half of a pair, low nybble on the second
    assign lookup_idx = hold_half_reg ? b[2:0] : b[6:4];
    assign looked     = cur_row[lookup_idx];

    cmnd_row_update u_row_update (
        .row_in  (cur_row),
        .sym     (out_sym),
        .row_out (upd_row)
    );

    // ------------------------------------------------------------------
    // Decode of the held request, one output byte per step
    // ------------------------------------------------------------------
    always_comb
    begin
        has_out     = 1'b0;
        coded       = 1'b0;
        done        = 1'b1;
        clear_lists = 1'b0;
        out_sym     = b;
        out_last    = 1'b1;
        phase_next  = phase_reg;
        pass_next   = pass_reg;
        prev_next   = prev_reg;

        if (hold_item_reg.block_start)
        begin
            // Header: drop all lists and pick the block kind
            clear_lists = 1'b1;
            prev_next   = 8'h00;
            pass_next   = 1'b0;
            if (b == 8'h00)
            begin
                phase_next = PH_HEADER;
            end
            else if (b == TYPE_NYBBLES)
            begin
                phase_next = PH_SEED;
            end
            else
            begin
                phase_next = PH_BLOCK;
                pass_next  = 1'b1;
                has_out    = (b != TYPE_COPY);
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_SEED:
                begin
                    // Seed goes out as is and sets the context, no list update
                    prev_next  = b;
                    phase_next = PH_BLOCK;
                    has_out    = 1'b1;
                end
                PH_BLOCK:
                begin
                    if (b == 8'h00)
                    begin
                        phase_next = PH_HEADER;
                        pass_next  = 1'b0;
                    end
                    else if (pass_reg)
                    begin
                        has_out = 1'b1;
                    end
                    else if (!b[7])
                    begin
                        has_out = 1'b1;
                        coded   = 1'b1;
                    end
                    else
                    begin
                        has_out  = 1'b1;
                        coded    = 1'b1;
                        out_sym  = looked;
                        out_last = hold_half_reg;
                        done     = hold_half_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (coded)
        begin
            prev_next = out_sym;
        end
    end

    assign out_space  = !out_valid_reg || dec_ready;
    assign step       = hold_valid_reg && (!has_out || out_space);
    assign code_ready = !hold_valid_reg || (step && done);
    assign row_write  = step && coded && adapt_reg;

    // ------------------------------------------------------------------
    // Held request: advance to the second half of a pair, drop when done
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            hold_half_reg  <= 1'b0;
        end
        else if (code_valid && code_ready)
        begin
            hold_valid_reg <= 1'b1;
            hold_half_reg  <= 1'b0;
        end
        else if (step)
        begin
            if (done)
            begin
                hold_valid_reg <= 1'b0;
            end
            else
            begin
                hold_half_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (code_valid && code_ready)
        begin
            hold_item_reg <= code_item;
        end
    end

    // ------------------------------------------------------------------
    // Decoder state and list flags
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            pass_reg      <= 1'b0;
            prev_reg      <= 8'h00;
            row_valid_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            pass_reg  <= pass_next;
            prev_reg  <= prev_next;
            if (clear_lists)
            begin
                row_valid_reg <= '0;
            end
            else if (row_write)
            begin
                row_valid_reg[ctx_rd] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (row_write)
        begin
            row_mem[ctx_rd] <= upd_row;
        end
    end

    // ------------------------------------------------------------------
    // Output register: hold while stalled
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step && has_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (dec_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && has_out)
        begin
            out_item_reg.out_byte    <= out_sym;
            out_item_reg.last_of_run <= out_last;
        end
    end

    assign dec_valid = out_valid_reg;
    assign dec_item  = out_item_reg;

endmodule

### sv/cmnd_row_update.sv
`timescale 1ns / 1ps
// Move-to-front update of one eight-entry context list.
// Depends on cmnd_pkg for the row type.
module cmnd_row_update (
    input  cmnd_pkg::mtf_row_t row_in,
    input  logic [7:0]         sym,
    output cmnd_pkg::mtf_row_t row_out
);
    import cmnd_pkg::*;

    logic [LIST_LEN-1:0] hit;
    logic [LIST_LEN-1:0] shift_en;

    // shift_en[i]: no earlier entry matches, so entry i takes its neighbour
    always_comb
    begin
        for (int i = 0; i < LIST_LEN; i++)
        begin
            hit[i] = (row_in[i] == sym);
        end
        shift_en[0] = 1'b1;
        for (int i = 1; i < LIST_LEN; i++)
        begin
            shift_en[i] = shift_en[i-1] & ~hit[i-1];
        end
        row_out[0] = sym;
        for (int i = 1; i < LIST_LEN; i++)
        begin
            row_out[i] = shift_en[i] ? row_in[i-1] : row_in[i];
        end
    end

endmodule

### dv/tb_context_mtf_nybble_decoder_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the context move-to-front nybble decoder top level.
// Depends on cmnd_pkg and the decoder RTL; drives requests, predicts decoded bytes,
// checks every decoded byte in order and writes adapt_enable between test phases.
module tb_context_mtf_nybble_decoder_top;

    import cmnd_pkg::*;

    localparam int         CTX_N         = CONTEXTS_DEFAULT;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         MAX_REPORTS   = 200;
    localparam logic [7:0] BLOCK_END     = 8'h00;   // ends a block; as a type byte, no block

    // Clock, reset and port signals; every input starts at a known value
    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  psel       = 1'b0;
    logic                  penable    = 1'b0;
    logic                  pwrite     = 1'b0;
    logic [APB_ADDR_W-1:0] paddr      = '0;
    logic [APB_DATA_W-1:0] pwdata     = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  code_valid = 1'b0;
    logic                  code_ready;
    code_item_t            code_item  = '0;
    logic                  dec_valid;
    logic                  dec_ready  = 1'b0;
    dec_item_t             dec_item;

    // Requests waiting to be driven and decoded bytes waiting to arrive
    code_item_t            pending_codes [$];
    dec_item_t             decoded_due   [$];
    int                    errors        = 0;
    int                    code_idle_pct = 18;
    int                    dec_stall_pct = 18;

    // Decoder state mirrored by the predictor
    logic [7:0]            ctx_list [CTX_N][LIST_LEN];
    logic [7:0]            last_byte;
    phase_t                blk_phase = PH_HEADER;
    logic                  copy_mode = 1'b0;
    logic                  adapt_on  = 1'b1;

    context_mtf_nybble_decoder_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .code_valid (code_valid),
        .code_ready (code_ready),
        .code_item  (code_item),
        .dec_valid  (dec_valid),
        .dec_ready  (dec_ready),
        .dec_item   (dec_item)
    );

    // 10 ns period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Context of a byte: bits 7:3 folded onto the number of lists
    function automatic int ctx_of_byte(logic [7:0] b);
        return int'(b[7:3]) % CTX_N;
    endfunction

    // Put every list back to space e t a o i n s
    function automatic void restore_lists();
        for (int c = 0; c < CTX_N; c++)
            for (int i = 0; i < LIST_LEN; i++)
                ctx_list[c][i] = INIT_ROW[i];
    endfunction

    // Move b to the front of list ctx; the last entry drops when b is absent
    function automatic void move_to_front(int ctx, logic [7:0] b);
        int hit;
        hit = LIST_LEN - 1;
        // scan from the back so that the first match wins
        for (int i = LIST_LEN - 1; i >= 0; i--)
            if (ctx_list[ctx][i] == b)
                hit = i;
        for (int i = hit; i > 0; i--)
            ctx_list[ctx][i] = ctx_list[ctx][i - 1];
        ctx_list[ctx][0] = b;
    endfunction

    function automatic void expect_byte(logic [7:0] b, logic last);
        dec_item_t due;
        due.out_byte    = b;
        due.last_of_run = last;
        decoded_due.push_back(due);
    endfunction

    // Decoded byte of a nybble block: update the previous byte's list, then advance
    function automatic void expect_coded(logic [7:0] b, logic last);
        if (adapt_on)
            move_to_front(ctx_of_byte(last_byte), b);
        last_byte = b;
        expect_byte(b, last);
    endfunction

    // Work out the decoded bytes one accepted request produces
    function automatic void decode_request(code_item_t req);
        logic [7:0] b;
        logic [7:0] first;
        logic [7:0] second;
        b = req.code_byte;
        if (req.block_start)
        begin
            restore_lists();
            last_byte = 8'h00;
            copy_mode = 1'b0;
            if (b == BLOCK_END)
                blk_phase = PH_HEADER;
            else if (b == TYPE_NYBBLES)
                blk_phase = PH_SEED;
            else
            begin
                blk_phase = PH_BLOCK;
                copy_mode = 1'b1;
                if (b != TYPE_COPY)
                    expect_byte(b, 1'b1);
            end
        end
        else if (blk_phase == PH_SEED)
        begin
            // the seed sets the context but never enters a list
            last_byte = b;
            blk_phase = PH_BLOCK;
            expect_byte(b, 1'b1);
        end
        else if (blk_phase == PH_BLOCK)
        begin
            if (b == BLOCK_END)
            begin
                blk_phase = PH_HEADER;
                copy_mode = 1'b0;
            end
            else if (copy_mode)
                expect_byte(b, 1'b1);
            else if (!b[7])
                expect_coded(b, 1'b1);
            else
            begin
                // high nybble first; bit 3 of each nybble is ignored
                first = ctx_list[ctx_of_byte(last_byte)][b[6:4]];
                expect_coded(first, 1'b0);
                second = ctx_list[ctx_of_byte(last_byte)][b[2:0]];
                expect_coded(second, 1'b1);
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Request driver: predict on acceptance, then offer the next request
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            code_valid <= 1'b0;
        else
        begin
            if (code_valid && code_ready)
                decode_request(code_item);
            // hold the request until it is taken; otherwise offer the next one
            if (!code_valid || code_ready)
            begin
                if (pending_codes.size() != 0 && $urandom_range(99) >= code_idle_pct)
                begin
                    code_item  <= pending_codes.pop_front();
                    code_valid <= 1'b1;
                end
                else
                    code_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Decoded byte monitor: compare with the oldest expectation, stall at random
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : dec_monitor
        dec_item_t due;
        if (!rst_n)
            dec_ready <= 1'b0;
        else
        begin
            if (dec_valid && dec_ready)
            begin
                if (decoded_due.size() == 0)
                begin
                    if (errors < MAX_REPORTS)
                        $error("out_byte: expected nothing, got %02h", dec_item.out_byte);
                    errors++;
                end
                else
                begin
                    due = decoded_due.pop_front();
                    if (dec_item.out_byte !== due.out_byte)
                    begin
                        if (errors < MAX_REPORTS)
                            $error("out_byte: expected %02h, got %02h",
                                   due.out_byte, dec_item.out_byte);
                        errors++;
                    end
                    if (dec_item.last_of_run !== due.last_of_run)
                    begin
                        if (errors < MAX_REPORTS)
                            $error("last_of_run: expected %0b, got %0b",
                                   due.last_of_run, dec_item.last_of_run);
                        errors++;
                    end
                end
            end
            dec_ready <= ($urandom_range(99) >= dec_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_code(logic [7:0] b, logic start);
        code_item_t req;
        req.code_byte   = b;
        req.block_start = start;
        pending_codes.push_back(req);
    endtask

    // Wait until every request is taken and every decoded byte has arrived,
    // then give a request that produced nothing time to finish
    task automatic settle();
        while (pending_codes.size() != 0 || code_valid || decoded_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write of adapt_enable: setup cycle, then access until pready
    task automatic write_adapt(logic value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_ADAPT_ENABLE, 2'b00};
        pwdata  <= APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        adapt_on  = value;
    endtask

    // One block with random content: mostly nybble blocks, closed by the end byte.
    // Some blocks are left open so the next header cuts in; ignored noise
    // between closed blocks is not counted.
    task automatic queue_random_block(inout int counted);
        int         pick;
        int         len;
        logic [7:0] hdr;
        logic [7:0] b;
        pick = $urandom_range(99);
        if (pick < 70)
            hdr = TYPE_NYBBLES;
        else if (pick < 80)
            hdr = TYPE_COPY;
        else if (pick < 85)
            hdr = BLOCK_END;
        else
            hdr = 8'($urandom_range(255));
        queue_code(hdr, 1'b1);
        counted++;
        if (hdr == BLOCK_END)
            return;
        if (hdr == TYPE_NYBBLES)
        begin
            queue_code(($urandom_range(9) == 0) ? 8'h00 : 8'($urandom_range(255)), 1'b0);
            counted++;
        end
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
        for (int i = 0; i < len; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 50)
                b = 8'h80 | 8'($urandom_range(127));
            else if (pick < 70)
                b = INIT_ROW[$urandom_range(LIST_LEN - 1)];
            else
                b = 8'($urandom_range(255, 1));
            queue_code(b, 1'b0);
            counted++;
        end
        if ($urandom_range(99) < 85)
        begin
            queue_code(BLOCK_END, 1'b0);
            counted++;
            if ($urandom_range(9) == 0)
                repeat ($urandom_range(3, 1))
                    queue_code(8'($urandom_range(255)), 1'b0);
        end
    endtask

    task automatic run_random_phase(int items);
        int counted;
        counted = 0;
        while (counted < items)
            queue_random_block(counted);
        settle();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        restore_lists();
        last_byte = 8'h00;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, adapt_enable at its reset value
        queue_code(8'h41, 1'b0);            // byte without a header: dropped
        queue_code(TYPE_COPY, 1'b1);        // copy block
        queue_code(8'hFF, 1'b0);
        queue_code(8'h80, 1'b0);
        queue_code(BLOCK_END, 1'b0);
        queue_code(BLOCK_END, 1'b1);        // zero type byte: no block
        queue_code(8'h5A, 1'b0);            // outside a block again
        queue_code(8'hFF, 1'b1);            // other type byte is itself output
        queue_code(8'h01, 1'b0);
        queue_code(TYPE_NYBBLES, 1'b1);     // header while in a block
        queue_code(8'h00, 1'b0);            // zero seed is data
        queue_code(8'h80, 1'b0);            // front entry twice
        queue_code(8'hFF, 1'b0);            // flag bit of the low nybble ignored
        queue_code(8'hF8, 1'b0);
        queue_code(8'h8F, 1'b0);
        queue_code(8'h7F, 1'b0);            // literals
        queue_code(8'h01, 1'b0);
        queue_code(8'hA5, 1'b0);
        queue_code(BLOCK_END, 1'b0);
        queue_code(TYPE_NYBBLES, 1'b1);
        queue_code(TYPE_NYBBLES, 1'b1);     // header while awaiting the seed
        queue_code(8'hFF, 1'b0);
        queue_code(8'hB6, 1'b0);
        queue_code(8'h65, 1'b0);
        queue_code(BLOCK_END, 1'b0);
        settle();

        // Random phases across adapt_enable settings; one with no idling at all
        write_adapt(1'b0);
        run_random_phase(130);
        write_adapt(1'b1);
        run_random_phase(130);
        code_idle_pct = 0;
        dec_stall_pct = 0;
        run_random_phase(130);
        code_idle_pct = 18;
        dec_stall_pct = 18;
        write_adapt(1'b0);
        run_random_phase(130);
        write_adapt(1'b1);
        run_random_phase(130);

        if (errors == 0)
            $display("tb_context_mtf_nybble_decoder_top passed");
        else
            $display("tb_context_mtf_nybble_decoder_top failed");
        $finish;
    end

    // Watchdog: end the run if it hangs
    initial
    begin
        #2_000_000;
        $display("tb_context_mtf_nybble_decoder_top failed");
        $finish;
    end

endmodule

### filelist.f
sv/cmnd_pkg.sv
sv/cmnd_row_update.sv
sv/context_mtf_nybble_decoder_top.sv
dv/tb_context_mtf_nybble_decoder_top.sv
